### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Types, command and status records and the witness table.
// ----------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

  localparam int W       = 63;
  localparam int NUM_WIT = 12;

  typedef logic [W-1:0] word_t;
  typedef logic [3:0]   widx_t;
  typedef logic [5:0]   cnt_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SHIFT_D, OP_INIT_W, OP_REDUCE_B,
    OP_MUL, OP_SHIFT_E, OP_SET_I, OP_INC_I, OP_NEXT_W
  } op_t;

  typedef enum logic [1:0] {
    MS_ACC_B, MS_B_B, MS_ACC_ACC
  } msel_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } cmd_t;

  typedef struct packed {
    logic m_lt2;
    logic m_eq_w;
    logic d_lsb;
    logic b_ge_m;
    logic e_zero;
    logic e_lsb;
    logic acc_one;
    logic acc_mm1;
    logic i_lt_twos;
    logic k_last;
    logic mul_busy;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_STRIP, ST_WIT, ST_REDUCE, ST_EXP, ST_MUL_A,
    ST_MUL_B, ST_CHK1, ST_SQ, ST_MUL_S, ST_NEXTW, ST_DONE
  } state_t;

  function automatic word_t witness_val(widx_t k);
    logic [5:0] v;
    begin
      unique case (k)
        4'd0:    v = 6'd2;
        4'd1:    v = 6'd3;
        4'd2:    v = 6'd5;
        4'd3:    v = 6'd7;
        4'd4:    v = 6'd11;
        4'd5:    v = 6'd13;
        4'd6:    v = 6'd17;
        4'd7:    v = 6'd19;
        4'd8:    v = 6'd23;
        4'd9:    v = 6'd29;
        4'd10:   v = 6'd31;
        4'd11:   v = 6'd37;
        default: v = 6'd0;
      endcase
      return word_t'(v);
    end
  endfunction

endpackage

`default_nettype wire

### rtl/mrpt_datapath.sv
// ----------------------------------------------------------------------------
// Miller-Rabin datapath
// Operand registers, counters and a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrpt_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mrpt_pkg::word_t candidate,
  input  wire mrpt_pkg::cmd_t  cmd,
  output mrpt_pkg::stat_t      stat
);
  import mrpt_pkg::*;

  word_t m_r, m_nxt, mm1_r, mm1_nxt, d_r, d_nxt;
  word_t acc_r, acc_nxt, b_r, b_nxt, e_r, e_nxt;
  cnt_t  twos_r, twos_nxt, i_r, i_nxt;
  widx_t k_r, k_nxt;
  word_t mx_r, mx_nxt, my_r, my_nxt, macc_r, macc_nxt;
  cnt_t  mbit_r, mbit_nxt;
  logic  mphase_r, mphase_nxt, mbusy_r, mbusy_nxt;
  msel_t mdest_r, mdest_nxt;

  logic [W:0] sum, red;
  word_t      mnew;

  // One modular addition per cycle: doubling in phase 0, adding x in phase 1.
  assign sum  = {1'b0, macc_r} + {1'b0, (mphase_r ? mx_r : macc_r)};
  assign red  = (sum >= {1'b0, m_r}) ? (sum - {1'b0, m_r}) : sum;
  assign mnew = my_r[W-1] ? red[W-1:0] : macc_r;

  always_comb begin
    m_nxt = m_r;  mm1_nxt = mm1_r;  d_nxt = d_r;  acc_nxt = acc_r;
    b_nxt = b_r;  e_nxt = e_r;  twos_nxt = twos_r;  i_nxt = i_r;  k_nxt = k_r;
    mx_nxt = mx_r;  my_nxt = my_r;  macc_nxt = macc_r;  mbit_nxt = mbit_r;
    mphase_nxt = mphase_r;  mbusy_nxt = mbusy_r;  mdest_nxt = mdest_r;

    unique case (cmd.op)
      OP_LOAD: begin
        m_nxt    = candidate;
        mm1_nxt  = candidate - word_t'(1);
        d_nxt    = candidate - word_t'(1);
        twos_nxt = '0;
        k_nxt    = '0;
      end
      OP_SHIFT_D: begin
        d_nxt    = d_r >> 1;
        twos_nxt = twos_r + cnt_t'(1);
      end
      OP_INIT_W: begin
        b_nxt   = witness_val(k_r);
        acc_nxt = word_t'(1);
        e_nxt   = d_r;
      end
      OP_REDUCE_B: b_nxt = b_r - m_r;
      OP_MUL: begin
        unique case (cmd.msel)
          MS_ACC_B:   begin mx_nxt = acc_r; my_nxt = b_r;   end
          MS_B_B:     begin mx_nxt = b_r;   my_nxt = b_r;   end
          MS_ACC_ACC: begin mx_nxt = acc_r; my_nxt = acc_r; end
          default:    begin mx_nxt = acc_r; my_nxt = acc_r; end
        endcase
        macc_nxt   = '0;
        mbit_nxt   = cnt_t'(W - 1);
        mphase_nxt = 1'b0;
        mbusy_nxt  = 1'b1;
        mdest_nxt  = cmd.msel;
      end
      OP_SHIFT_E: e_nxt = e_r >> 1;
      OP_SET_I:   i_nxt = cnt_t'(1);
      OP_INC_I:   i_nxt = i_r + cnt_t'(1);
      OP_NEXT_W:  k_nxt = k_r + widx_t'(1);
      default: ;
    endcase

    if (mbusy_r) begin
      if (!mphase_r) begin
        macc_nxt   = red[W-1:0];
        mphase_nxt = 1'b1;
      end else begin
        macc_nxt   = mnew;
        my_nxt     = my_r << 1;
        mphase_nxt = 1'b0;
        mbit_nxt   = mbit_r - cnt_t'(1);
        if (mbit_r == '0) begin
          mbusy_nxt = 1'b0;
          if (mdest_r == MS_B_B) b_nxt = mnew;
          else acc_nxt = mnew;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;  mm1_r <= mm1_nxt;  d_r <= d_nxt;  acc_r <= acc_nxt;
    b_r <= b_nxt;  e_r <= e_nxt;  twos_r <= twos_nxt;  i_r <= i_nxt;  k_r <= k_nxt;
    mx_r <= mx_nxt;  my_r <= my_nxt;  macc_r <= macc_nxt;  mbit_r <= mbit_nxt;
    mphase_r <= mphase_nxt;  mdest_r <= mdest_nxt;
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else begin
      mbusy_r <= mbusy_nxt;
    end
  end

  always_comb begin
    stat.m_lt2     = (m_r[W-1:1] == '0);
    stat.m_eq_w    = (m_r == witness_val(k_r));
    stat.d_lsb     = d_r[0];
    stat.b_ge_m    = (b_r >= m_r);
    stat.e_zero    = (e_r == '0);
    stat.e_lsb     = e_r[0];
    stat.acc_one   = (acc_r == word_t'(1));
    stat.acc_mm1   = (acc_r == mm1_r);
    stat.i_lt_twos = (i_r < twos_r);
    stat.k_last    = (k_r == widx_t'(NUM_WIT - 1));
    stat.mul_busy  = mbusy_r;
  end

  `AST_IMP(a_no_restart, cmd.op == OP_MUL, !mbusy_r)
  `AST_NXT(a_mul_ends, mbusy_r && mphase_r && (mbit_r == '0), !mbusy_r)

endmodule

`default_nettype wire

### rtl/mrpt_ctrl.sv
// ----------------------------------------------------------------------------
// Miller-Rabin controller
// Sequences the test, drives datapath commands and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrpt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_prime_flag,
  input  wire mrpt_pkg::stat_t stat,
  output mrpt_pkg::cmd_t      cmd
);
  import mrpt_pkg::*;

  state_t state_r, state_nxt;
  logic   res_r, res_nxt;
  logic   ov_r, ov_nxt, of_r, of_nxt;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    of_r  <= of_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    of_nxt    = of_r;
    ov_nxt    = ov_r && !out_ready;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.msel  = MS_ACC_B;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.m_lt2) begin
          res_nxt = 1'b0; state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!stat.d_lsb) cmd.op = OP_SHIFT_D;
        else state_nxt = ST_WIT;
      end
      ST_WIT: begin
        if (stat.m_eq_w) begin
          res_nxt = 1'b1; state_nxt = ST_DONE;
        end else begin
          cmd.op = OP_INIT_W; state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (stat.b_ge_m) cmd.op = OP_REDUCE_B;
        else state_nxt = ST_EXP;
      end
      ST_EXP: begin
        if (stat.e_zero) begin
          state_nxt = ST_CHK1;
        end else if (stat.e_lsb) begin
          cmd.op = OP_MUL; cmd.msel = MS_ACC_B; state_nxt = ST_MUL_A;
        end else begin
          cmd.op = OP_MUL; cmd.msel = MS_B_B; state_nxt = ST_MUL_B;
        end
      end
      ST_MUL_A: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_MUL; cmd.msel = MS_B_B; state_nxt = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_SHIFT_E; state_nxt = ST_EXP;
        end
      end
      ST_CHK1: begin
        if (stat.acc_one || stat.acc_mm1) begin
          state_nxt = ST_NEXTW;
        end else begin
          cmd.op = OP_SET_I; state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (stat.i_lt_twos) begin
          cmd.op = OP_MUL; cmd.msel = MS_ACC_ACC; state_nxt = ST_MUL_S;
        end else begin
          res_nxt = 1'b0; state_nxt = ST_DONE;
        end
      end
      ST_MUL_S: begin
        if (!stat.mul_busy) begin
          if (stat.acc_mm1) begin
            state_nxt = ST_NEXTW;
          end else begin
            cmd.op = OP_INC_I; state_nxt = ST_SQ;
          end
        end
      end
      ST_NEXTW: begin
        if (stat.k_last) begin
          res_nxt = 1'b1; state_nxt = ST_DONE;
        end else begin
          cmd.op = OP_NEXT_W; state_nxt = ST_WIT;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          of_nxt    = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_prime_flag = of_r;

  `AST_NXT(a_accept_starts, in_valid && in_ready, state_r == ST_CHECK)
  `AST_NXT(a_done_fills_out, (state_r == ST_DONE) && (!ov_r || out_ready), ov_r)

endmodule

`default_nettype wire

### rtl/miller_rabin_prime_test.sv
// ----------------------------------------------------------------------------
// Miller-Rabin prime test, top level
// Deterministic primality test of 63-bit candidates with witnesses 2 to 37.
// ----------------------------------------------------------------------------
// Use: a candidate is offered on in_candidate with in_valid; the transaction
// completes when in_ready is also high. One result transaction follows on
// out_prime_flag with out_valid, held until out_ready takes it.
// Latency depends on the candidate. Each modular product runs on one shared
// bit-serial multiplier that doubles and then conditionally adds once per
// operand bit. A large prime runs all 12 witnesses. Values below two finish
// before any witness, a composite stops at the first witness that rejects
// it, and a prime equal to a witness stops when that witness is reached.
// Only one candidate is in work at a time; in_ready is high while the
// controller is idle, even if the previous result still waits in the output
// register.
// Reset (synchronous, active low) returns the controller to idle and empties
// the output register. A stalled receiver holds the finished result in the
// output register, and a following result waits until that slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_prime_test (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mrpt_pkg::word_t in_candidate,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_prime_flag
);
  import mrpt_pkg::*;

  // Command and status records between sequencer and datapath.
  cmd_t  cmd;
  stat_t stat;

  mrpt_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_prime_flag (out_prime_flag),
    .stat           (stat),
    .cmd            (cmd)
  );

  // The datapath holds the candidate, the odd part of candidate minus one,
  // the exponentiation registers and the modular multiplier.
  mrpt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_candidate),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
